[hdl/itrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_pkg: shared definitions for the radix digit converter
// Constants, the digit-to-ASCII mapping and the divider control structs.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 32;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;  // 'A' minus ten

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d > DIGIT_MAX) begin
      return ext + CHAR_LETTER;
    end
    return ext + CHAR_ZERO;
  endfunction

endpackage

[hdl/itrd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/itrd_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_divider: bit-serial restoring divider by a small radix
// Shifts the dividend through one bit per cycle against a 4-bit partial
// remainder, giving the quotient and remainder when done is raised.
// ----------------------------------------------------------------------------
module itrd_divider #(
  parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  itrd_pkg::div_ctrl_t          ctrl,
  input  logic [VALUE_WIDTH-1:0]       dividend,
  input  logic [itrd_pkg::RADIX_W-1:0] divisor,
  output itrd_pkg::div_stat_t          stat,
  output logic [VALUE_WIDTH-1:0]       quotient,
  output logic [itrd_pkg::DIGIT_W-1:0] remainder
);
  import itrd_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [CW-1:0]      cnt;
  logic [RADIX_W-1:0] trial;
  logic [RADIX_W-1:0] diff;
  logic               fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {remainder, quotient[VALUE_WIDTH-1]};
  assign fits  = (trial >= divisor);
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (ctrl.start) begin
        stat.busy <= 1'b1;
        cnt       <= CW'(VALUE_WIDTH);
        quotient  <= dividend;
        remainder <= '0;
      end else if (stat.busy) begin
        quotient  <= {quotient[VALUE_WIDTH-2:0], fits};
        remainder <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        cnt       <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/integer_to_radix_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits: unsigned integer to ASCII digits in radix 2..16
// Converts one value per run and emits its digits most significant first.
// ----------------------------------------------------------------------------
// Each accepted word is divided by the radix again and again until the
// quotient reaches zero (or MAX_DIGITS digits have been produced), and every
// remainder is pushed onto a small stack RAM. The stack is then popped, so
// the digits leave most significant first as ASCII '0'-'9' and 'A'-'F', one
// output word per digit, with last_digit set on the least significant one.
// A zero value gives the single digit '0'. Radix register values below two
// act as two and values above sixteen act as sixteen; the radix in force is
// sampled when a value is accepted. For each digit the bit-serial divider is
// started, shifts in every dividend bit and hands its remainder over to be
// pushed onto the stack. Each digit is then read from the stack, lands in the
// output register and waits there until the consumer takes it, so popping
// slows down whenever the consumer stalls. A new value is taken as soon as
// the last digit of the previous run sits in the output register, even if
// it has not been taken.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
  parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = itrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: radix register
  input  logic                         cfg_we,
  input  logic [itrd_pkg::RADIX_W-1:0] cfg_data,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [VALUE_WIDTH-1:0]       value,
  // output words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]  digit_char,
  output logic                         last_digit
);
  import itrd_pkg::*;

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DIV_START = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
  localparam logic [2:0] ST_READ      = 3'd3;
  localparam logic [2:0] ST_LAND      = 3'd4;

  logic [2:0]             state;
  logic [RADIX_W-1:0]     radix;
  logic [RADIX_W-1:0]     run_radix;
  logic [RADIX_W-1:0]     eff_radix;
  logic [VALUE_WIDTH-1:0] working_quotient;
  logic [CW-1:0]          stack_count;
  logic [CW-1:0]          count_inc;
  logic                   last_pend;

  div_ctrl_t              div_ctrl;
  div_stat_t              div_stat;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_rem;

  logic                   push;
  logic                   pop;
  logic [AW-1:0]          pop_addr;
  logic [DIGIT_W-1:0]     pop_data;

  // Out-of-range radix settings are clamped to the nearest legal base.
  always_comb begin
    if (radix < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix;
    end
  end

  assign in_ready       = (state == ST_IDLE);
  assign div_ctrl.start = (state == ST_DIV_START);
  assign count_inc      = stack_count + 1'b1;
  assign push           = (state == ST_DIV_WAIT) && div_stat.done;
  // A pop is issued only when the output register is free, so the word that
  // lands next cycle never overwrites one that is still waiting.
  assign pop            = (state == ST_READ) && !out_valid;
  assign pop_addr       = AW'(stack_count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      stack_count      <= '0;
      working_quotient <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            working_quotient <= value;
            run_radix        <= eff_radix;
            stack_count      <= '0;
            state            <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            working_quotient <= div_quot;
            stack_count      <= count_inc;
            // Stop on a zero quotient, or when the stack is full and the
            // more significant digits have to be dropped.
            if (div_quot == '0 || count_inc == CW'(MAX_DIGITS)) begin
              state <= ST_READ;
            end else begin
              state <= ST_DIV_START;
            end
          end
        end
        ST_READ: begin
          if (!out_valid) begin
            stack_count <= stack_count - 1'b1;
            last_pend   <= (stack_count == CW'(1));
            state       <= ST_LAND;
          end
        end
        ST_LAND: begin
          digit_char <= to_ascii(pop_data);
          last_digit <= last_pend;
          out_valid  <= 1'b1;
          state      <= last_pend ? ST_IDLE : ST_READ;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  itrd_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (working_quotient),
    .divisor  (run_radix),
    .stat     (div_stat),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  itrd_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_stack (
    .clk  (clk),
    .we   (push),
    .waddr(stack_count[AW-1:0]),
    .wdata(div_rem),
    .re   (pop),
    .raddr(pop_addr),
    .rdata(pop_data)
  );

endmodule

[hdl/itrd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_checker: port-level checks for the radix digit converter
// Watches the handshakes and digit codes, attached to the top level by bind.
// ----------------------------------------------------------------------------
module itrd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [itrd_pkg::CHAR_W-1:0] digit_char,
  input logic                        last_digit
);
  import itrd_pkg::*;

  // A stalled output word keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
    else $error("output word changed while stalled");

  // Only decimal digits and the letters A through F are ever produced.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
                   (digit_char >= 7'd65 && digit_char <= 7'd70)))
    else $error("digit character out of range");

  // After a word is taken the block is busy converting it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  // No new word is taken right after a digit other than the last one of a run is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_digit |=> !in_ready)
    else $error("input ready in the middle of a digit run");

endmodule

bind integer_to_radix_digits itrd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .digit_char(digit_char),
  .last_digit(last_digit)
);
